// File: rtl/core/lqt_pkg.sv
// Shared types, constants and element conversion functions for the linear queue block.
// Depends on nothing; imported by lqt_seq and linear_queue_with_traversal.
`default_nettype none

package lqt_pkg;

   localparam int DEPTH      = 64;
   localparam int DATA_WIDTH = 32;
   localparam int IDX_W      = $clog2(DEPTH);
   localparam int CNT_W      = $clog2(DEPTH + 1);
   localparam int CAP_W      = 7;
   localparam int CMD_W      = 2;
   localparam int ST_W       = 2;
   localparam int ELEM_W     = 32;

   typedef enum logic [CMD_W-1:0] {
      CMD_ENQ = 2'd0,
      CMD_DEQ = 2'd1,
      CMD_FWD = 2'd2,
      CMD_REV = 2'd3
   } cmd_type;

   typedef enum logic [ST_W-1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   // one result item in flight between the read issue and the output queue
   typedef struct packed {
      logic       valid;
      status_type status;
      logic       last;
      logic       use_ram;
   } stage_type;

   // output queue state seen by the sequencer
   typedef struct packed {
      logic [1:0] occ;
      logic       pop;
   } oq_stat_type;

   function automatic logic [DATA_WIDTH-1:0] to_store(input logic [ELEM_W-1:0] din);
      logic [63:0] wide;
      wide = 64'($signed(din));
      return wide[DATA_WIDTH-1:0];
   endfunction

   function automatic logic [ELEM_W-1:0] to_output(input logic [DATA_WIDTH-1:0] stored);
      logic [63:0] wide;
      wide = 64'($signed(stored));
      return wide[ELEM_W-1:0];
   endfunction

endpackage

`default_nettype wire

// File: rtl/core/lqt_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Stand-alone; used for the slot store.
`default_nettype none

module lqt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: rtl/core/lqt_seq.sv
// Command sequencer: head and fill pointers, capacity register, slot store access
// and traversal stepping. Depends on lqt_pkg.
`default_nettype none

module lqt_seq
   import lqt_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [CMD_W-1:0]      req_command,
   input  wire logic [ELEM_W-1:0]     req_data_value,
   input  wire logic                  csr_valid,
   input  wire logic [CAP_W-1:0]      csr_capacity,
   input  wire oq_stat_type           oq_stat,
   output logic                       wr_en,
   output logic [IDX_W-1:0]           wr_addr,
   output logic [DATA_WIDTH-1:0]      wr_data,
   output logic                       rd_en,
   output logic [IDX_W-1:0]           rd_addr,
   output stage_type                  stage
);

   typedef enum logic {
      S_IDLE,
      S_TRAV
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] head_ff, head_in;
   logic [CNT_W-1:0] wc_ff, wc_in;
   logic [CAP_W-1:0] cap_ff;
   logic [IDX_W-1:0] cur_ff, cur_in;
   logic [CNT_W-1:0] rem_ff, rem_in;
   logic             dir_ff, dir_in;
   stage_type        stage_ff, stage_in;

   logic [2:0]       load;
   logic             room;
   logic             accept;
   logic             empty;
   logic             full;
   logic [CAP_W-1:0] eff_cap;
   logic [CNT_W-1:0] count;
   logic [IDX_W-1:0] first_idx;
   cmd_type          cmd;

   assign load   = 3'(oq_stat.occ) + 3'(stage_ff.valid) - 3'(oq_stat.pop);
   assign room   = load < 3'd2;
   assign cmd    = cmd_type'(req_command);
   assign accept = req_valid && req_ready;
   assign empty  = head_ff >= wc_ff;
   assign count  = wc_ff - head_ff;

   always_comb begin
      if (cap_ff == '0) begin
         eff_cap = CAP_W'(1);
      end else if (cap_ff > CAP_W'(DEPTH)) begin
         eff_cap = CAP_W'(DEPTH);
      end else begin
         eff_cap = cap_ff;
      end
   end

   assign full = CAP_W'(wc_ff) >= eff_cap;

   always_comb begin
      req_ready = (state_ff == S_IDLE) && room;
      state_in  = state_ff;
      head_in   = head_ff;
      wc_in     = wc_ff;
      cur_in    = cur_ff;
      rem_in    = rem_ff;
      dir_in    = dir_ff;
      stage_in  = '0;
      wr_en     = 1'b0;
      wr_addr   = wc_ff[IDX_W-1:0];
      wr_data   = to_store(req_data_value);
      rd_en     = 1'b0;
      rd_addr   = cur_ff;
      first_idx = (cmd == CMD_FWD) ? head_ff[IDX_W-1:0] : IDX_W'(wc_ff - CNT_W'(1));

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               stage_in.valid = 1'b1;
               stage_in.last  = 1'b1;
               stage_in.status = ST_OK;
               case (cmd)
                  CMD_ENQ: begin
                     if (full) begin
                        stage_in.status = ST_FULL;
                     end else begin
                        wr_en = 1'b1;
                        wc_in = wc_ff + CNT_W'(1);
                     end
                  end
                  CMD_DEQ: begin
                     if (empty) begin
                        stage_in.status = ST_EMPTY;
                     end else begin
                        rd_en            = 1'b1;
                        rd_addr          = head_ff[IDX_W-1:0];
                        head_in          = head_ff + CNT_W'(1);
                        stage_in.use_ram = 1'b1;
                     end
                  end
                  default: begin
                     if (empty) begin
                        stage_in.status = ST_EMPTY;
                     end else begin
                        rd_en            = 1'b1;
                        rd_addr          = first_idx;
                        stage_in.use_ram = 1'b1;
                        if (count != CNT_W'(1)) begin
                           stage_in.last = 1'b0;
                           state_in      = S_TRAV;
                           dir_in        = (cmd == CMD_FWD);
                           cur_in        = (cmd == CMD_FWD) ? first_idx + IDX_W'(1)
                                                            : first_idx - IDX_W'(1);
                           rem_in        = count - CNT_W'(1);
                        end
                     end
                  end
               endcase
            end
         end
         S_TRAV: begin
            if (room) begin
               rd_en            = 1'b1;
               stage_in.valid   = 1'b1;
               stage_in.status  = ST_OK;
               stage_in.use_ram = 1'b1;
               stage_in.last    = (rem_ff == CNT_W'(1));
               rem_in           = rem_ff - CNT_W'(1);
               cur_in           = dir_ff ? cur_ff + IDX_W'(1) : cur_ff - IDX_W'(1);
               if (rem_ff == CNT_W'(1)) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         head_ff  <= '0;
         wc_ff    <= '0;
         cap_ff   <= CAP_W'(64);
         stage_ff <= '0;
         cur_ff   <= '0;
         rem_ff   <= '0;
         dir_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         wc_ff    <= wc_in;
         stage_ff <= stage_in;
         cur_ff   <= cur_in;
         rem_ff   <= rem_in;
         dir_ff   <= dir_in;
         if (csr_valid) begin
            cap_ff <= csr_capacity;
         end
      end
   end

   assign stage = stage_ff;

endmodule

`default_nettype wire

// File: rtl/core/linear_queue_with_traversal.sv
// Top level of the array-backed linear queue with head/tail traversal.
// Depends on lqt_pkg, lqt_seq and lqt_ram.
//
// Usage:
//   req channel  : command and data_value; one item per accepted handshake.
//   rsp channel  : status, element_value and last_of_run; one or more items
//                  per request, last_of_run marks the final one.
//   csr channel  : capacity write, always ready; write only while idle.
// Path: a result is registered with the slot store read, then held in the
//   output queue, which drives rsp.
// Throughput: one enqueue or dequeue per cycle while the output queue has
//   room; a traversal reads one held element per cycle while there is room,
//   set by the slot store's single read port. Empty traversals give one item.
// Reset: head and fill pointers clear, capacity returns to 64; the slot store
//   keeps no reset value and is only read where written.
// Stall: a two-entry output queue holds results; reads are issued only when
//   a place is free, so a stalled receiver holds the traversal and the req
//   channel without losing an item.
`default_nettype none

module linear_queue_with_traversal
   import lqt_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic [CMD_W-1:0]  req_command,
   input  wire logic [ELEM_W-1:0] req_data_value,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic [ST_W-1:0]        rsp_status,
   output logic [ELEM_W-1:0]      rsp_element_value,
   output logic                   rsp_last_of_run,
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [CAP_W-1:0]  csr_capacity
);

   oq_stat_type           oq_stat;
   stage_type             stage;
   logic                  wr_en;
   logic [IDX_W-1:0]      wr_addr;
   logic [DATA_WIDTH-1:0] wr_data;
   logic                  rd_en;
   logic [IDX_W-1:0]      rd_addr;
   logic [DATA_WIDTH-1:0] rd_data;

   logic [ST_W-1:0]       oq_status_ff [2];
   logic [ELEM_W-1:0]     oq_elem_ff   [2];
   logic                  oq_last_ff   [2];
   logic                  wr_ptr_ff, wr_ptr_in;
   logic                  rd_ptr_ff, rd_ptr_in;
   logic [1:0]            count_ff, count_in;
   logic                  push;
   logic                  pop;
   logic [ELEM_W-1:0]     push_elem;

   assign csr_ready = 1'b1;

   lqt_seq u_seq (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_command    (req_command),
      .req_data_value (req_data_value),
      .csr_valid      (csr_valid),
      .csr_capacity   (csr_capacity),
      .oq_stat        (oq_stat),
      .wr_en          (wr_en),
      .wr_addr        (wr_addr),
      .wr_data        (wr_data),
      .rd_en          (rd_en),
      .rd_addr        (rd_addr),
      .stage          (stage)
   );

   lqt_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (DEPTH)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign push      = stage.valid;
   assign pop       = rsp_valid && rsp_ready;
   assign push_elem = stage.use_ram ? to_output(rd_data) : '0;

   assign oq_stat.occ = count_ff;
   assign oq_stat.pop = pop;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         oq_status_ff[wr_ptr_ff] <= stage.status;
         oq_elem_ff[wr_ptr_ff]   <= push_elem;
         oq_last_ff[wr_ptr_ff]   <= stage.last;
      end
   end

   assign rsp_valid         = count_ff != 2'd0;
   assign rsp_status        = oq_status_ff[rd_ptr_ff];
   assign rsp_element_value = oq_elem_ff[rd_ptr_ff];
   assign rsp_last_of_run   = oq_last_ff[rd_ptr_ff];

endmodule

`default_nettype wire
